### hdl/keyed_count_store_defines.svh
// ----------------------------------------------------------------------------
// keyed_count_store assertion macros
// shared property shorthands for the checker of the keyed count store
// ----------------------------------------------------------------------------
`ifndef KEYED_COUNT_STORE_DEFINES_SVH
`define KEYED_COUNT_STORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed_count_store: same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define KCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_count_store: next-cycle check failed");

`endif

### hdl/kcs_pkg.sv
// ----------------------------------------------------------------------------
// kcs_pkg
// field widths, controller states and the command bundle of the count store
// ----------------------------------------------------------------------------
package kcs_pkg;

  localparam int KEY_W  = 14;
  localparam int CNT_W  = 16;
  localparam int USED_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [USED_W-1:0] used_t;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic search;  // register key match and free entry
    logic commit;  // write back the entry and fill the result register
  } cmd_t;

endpackage

### hdl/kcs_ctrl.sv
// ----------------------------------------------------------------------------
// kcs_ctrl
// sequencer for the count store: search, then read-modify-write and result
// ----------------------------------------------------------------------------
module kcs_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output kcs_pkg::cmd_t cmd
);
  import kcs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   wb_ready;
  logic   in_xfer;

  // update may finish once the result register is free or draining
  assign wb_ready = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || !((state_r == ST_IDLE) || wb_ready);
  assign in_xfer  = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (wb_ready) state_nxt = in_xfer ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wb_ready) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // commands
  assign cmd.load   = in_xfer;
  assign cmd.search = (state_r == ST_SEARCH);
  assign cmd.commit = wb_ready;
  assign out_valid  = out_valid_r;

endmodule

### hdl/kcs_dpath.sv
// ----------------------------------------------------------------------------
// kcs_dpath
// entry table with parallel key compare, count update and result register
// ----------------------------------------------------------------------------
module kcs_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  kcs_pkg::cmd_t   cmd,
  input  logic            in_action,
  input  kcs_pkg::key_t   in_key,
  input  kcs_pkg::cnt_t   in_amount,
  output kcs_pkg::cnt_t   out_taken,
  output logic            out_hit,
  output logic            out_overflow,
  output kcs_pkg::used_t  out_entries_used
);
  import kcs_pkg::*;

  localparam int UCNT_W = $clog2(TABLE_DEPTH + 1);

  // entry table
  key_t                   entry_key_r   [TABLE_DEPTH];
  cnt_t                   entry_count_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid_r;
  logic [UCNT_W-1:0]      used_r, used_nxt;

  // item being worked on
  logic action_r;
  key_t key_r;
  cnt_t amount_r;

  // search results
  logic [TABLE_DEPTH-1:0] match_r, match_nxt;
  logic [TABLE_DEPTH-1:0] free_oh_r, free_oh_nxt;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic                   hit_r, free_any_r;

  // update path
  cnt_t            sel_count;
  logic [CNT_W:0]  sum;
  cnt_t            dep_count, take_amt, remain, new_count;
  logic            deposit, alloc, overflow, release_entry;
  logic [UCNT_W+USED_W-1:0] used_wide;

  // result register
  cnt_t  taken_r;
  logic  res_hit_r, res_ovf_r;
  used_t res_used_r;

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      key_r    <= in_key;
      amount_r <= in_amount;
    end
  end

  // key compare against every entry, lowest free entry
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_nxt[i] = entry_valid_r[i] && (entry_key_r[i] == key_r);
    end
    free_vec    = ~entry_valid_r;
    free_oh_nxt = free_vec & (~free_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_r    <= match_nxt;
      free_oh_r  <= free_oh_nxt;
      hit_r      <= |match_nxt;
      free_any_r <= |free_vec;
    end
  end

  // matched count, keys are unique so at most one term is live
  always_comb begin
    sel_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_count = sel_count | (entry_count_r[i] & {CNT_W{match_r[i]}});
    end
  end

  // saturating add for deposit, bounded subtract for take
  always_comb begin
    sum           = {1'b0, sel_count} + {1'b0, amount_r};
    dep_count     = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
    take_amt      = (sel_count < amount_r) ? sel_count : amount_r;
    remain        = sel_count - take_amt;
    deposit       = !action_r;
    new_count     = deposit ? dep_count : remain;
    alloc         = deposit && !hit_r && free_any_r;
    overflow      = deposit && !hit_r && !free_any_r;
    release_entry = !deposit && hit_r && (remain == '0);
    used_nxt      = used_r;
    if (alloc) used_nxt = used_r + {{(UCNT_W-1){1'b0}}, 1'b1};
    else if (release_entry) used_nxt = used_r - {{(UCNT_W-1){1'b0}}, 1'b1};
    used_wide     = {{USED_W{1'b0}}, used_nxt};
  end

  // entry payload write-back
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (hit_r && match_r[i]) begin
          entry_count_r[i] <= new_count;
          if (release_entry) entry_key_r[i] <= '0;
        end else if (alloc && free_oh_r[i]) begin
          entry_key_r[i]   <= key_r;
          entry_count_r[i] <= amount_r;
        end
      end
    end
  end

  // valid bits and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      used_r        <= '0;
    end else if (cmd.commit) begin
      used_r <= used_nxt;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (release_entry && match_r[i]) entry_valid_r[i] <= 1'b0;
        else if (alloc && free_oh_r[i]) entry_valid_r[i] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      taken_r    <= (!deposit && hit_r) ? take_amt : '0;
      res_hit_r  <= hit_r;
      res_ovf_r  <= overflow;
      res_used_r <= used_wide[USED_W-1:0];
    end
  end

  assign out_taken        = taken_r;
  assign out_hit          = res_hit_r;
  assign out_overflow     = res_ovf_r;
  assign out_entries_used = res_used_r;

endmodule

### hdl/keyed_count_store.sv
// ----------------------------------------------------------------------------
// keyed_count_store
// associative table of key/count entries with deposit and take items
// ----------------------------------------------------------------------------
//  channel  ports                                         direction
//  in       in_valid in_stall in_action in_key in_amount  item in
//  out      out_valid out_stall out_taken out_hit
//           out_overflow out_entries_used                 result out
//
//  an item passes a search state (parallel key compare, free-entry pick),
//  then an update state (read-modify-write of the matched or new entry).
//  a new item is taken in the cycle the previous one writes back.
//  the result register frees the input side; a held result stalls the
//  write-back of the next item and, while that waits, the input side.
//  reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_count_store #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_action,
  input  kcs_pkg::key_t   in_key,
  input  kcs_pkg::cnt_t   in_amount,
  output logic            out_valid,
  input  logic            out_stall,
  output kcs_pkg::cnt_t   out_taken,
  output logic            out_hit,
  output logic            out_overflow,
  output kcs_pkg::used_t  out_entries_used
);
  import kcs_pkg::*;

  cmd_t cmd;

  // sequencer
  kcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // table and result path
  kcs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_key           (in_key),
    .in_amount        (in_amount),
    .out_taken        (out_taken),
    .out_hit          (out_hit),
    .out_overflow     (out_overflow),
    .out_entries_used (out_entries_used)
  );

endmodule

### hdl/kcs_checker.sv
// ----------------------------------------------------------------------------
// kcs_checker
// port-level checks of the count store, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_count_store_defines.svh"

module kcs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input kcs_pkg::cnt_t  out_taken,
  input logic           out_hit,
  input logic           out_overflow
);
  import kcs_pkg::*;

  // a held result stays offered
  `KCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // a transfer in is followed by a search cycle that takes no item
  `KCS_ASSERT_NXT(a_in_busy, in_valid && !in_stall, in_stall)

  // overflow only on a miss
  `KCS_ASSERT_IMP(a_ovf_miss, out_valid && out_overflow, !out_hit && (out_taken == '0))

  // nothing is taken without a matching entry
  `KCS_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_taken == '0)

endmodule

bind keyed_count_store kcs_checker u_kcs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_taken    (out_taken),
  .out_hit      (out_hit),
  .out_overflow (out_overflow)
);
